@@ hw/rtl/oks_pkg.sv @@
package oks_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_EXISTS = 3'd2;
    localparam logic [2:0] ACT_NEXT   = 3'd3;
    localparam logic [2:0] ACT_PREV   = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic        found;
        logic [31:0] neighbor_key;
        logic [1:0]  status;
    } oks_result_t;

endpackage

@@ hw/rtl/oks_store.sv @@
// Sorted key store: one synchronous memory, one read and one write port.
module oks_store #(
    parameter int CAPACITY = oks_pkg::CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);
    logic [31:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ hw/rtl/oks_ctrl.sv @@
// Sequencer: binary search over the store, then shift for insert/delete.
module oks_ctrl #(
    parameter int CAPACITY = oks_pkg::CAPACITY_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 2)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    in_action,
    input  logic [31:0]   in_key,
    output logic          res_valid,
    input  logic          res_ready,
    output oks_pkg::oks_result_t res,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [31:0]   wr_data,
    output logic [AW-1:0] rd_addr,
    input  logic [31:0]   rd_data
);
    import oks_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_NBR   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  act_reg, act_next;
    logic [31:0] u_reg, u_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          pres_reg, pres_next;
    oks_result_t   res_reg, res_next;
    oks_result_t   out_reg, out_next;
    logic          rv_reg, rv_next;
    logic [CW-1:0] mid;
    logic [CW-1:0] rd_idx;
    logic [31:0]   rd_u;

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_u      = rd_data;
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = rv_reg;
    assign res       = out_reg;
    assign rd_addr   = rd_idx[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        u_next     = u_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        pres_next  = pres_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        rv_next    = rv_reg;
        rd_idx     = mid;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = u_reg;
        if (rv_reg && res_ready)
        begin
            rv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    act_next   = in_action;
                    u_next     = {~in_key[31], in_key[30:0]};
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRCH;
                end
            end
            // issue read at mid, or finish search and read entry lo
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    idx_next   = mid;
                    state_next = S_CHK;
                end
                else
                begin
                    rd_idx     = lo_reg;
                    idx_next   = lo_reg;
                    hi_next    = '1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (hi_reg != '1)
                begin
                    if (rd_u < u_reg)
                    begin
                        lo_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = idx_reg;
                    end
                    state_next = S_SRCH;
                end
                else
                begin
                    // idx_reg = pos, rd_data = entry pos
                    pres_next = (idx_reg < count_reg) && (rd_u == u_reg);
                    res_next  = '{found: 1'b0, neighbor_key: 32'd0, status: ST_NONE};
                    state_next = S_OUT;
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            if ((idx_reg < count_reg) && (rd_u == u_reg))
                            begin
                                res_next.status = ST_DONE;
                            end
                            else if (count_reg >= CW'(CAPACITY))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                res_next.status = ST_DONE;
                                lo_next    = idx_reg;
                                idx_next   = count_reg;
                                rd_idx     = count_reg - 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if ((idx_reg < count_reg) && (rd_u == u_reg))
                            begin
                                res_next.status = ST_DONE;
                                rd_idx     = idx_reg + 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        ACT_EXISTS:
                        begin
                            if ((idx_reg < count_reg) && (rd_u == u_reg))
                            begin
                                res_next.found  = 1'b1;
                                res_next.status = ST_DONE;
                            end
                        end
                        ACT_NEXT:
                        begin
                            if ((idx_reg < count_reg) && (rd_u == u_reg))
                            begin
                                idx_next = idx_reg + 1'b1;
                                rd_idx   = idx_reg + 1'b1;
                                state_next = S_NBR;
                            end
                            else if (idx_reg < count_reg)
                            begin
                                res_next = '{found: 1'b1,
                                    neighbor_key: {~rd_u[31], rd_u[30:0]},
                                    status: ST_DONE};
                            end
                        end
                        ACT_PREV:
                        begin
                            if (idx_reg != '0)
                            begin
                                rd_idx     = idx_reg - 1'b1;
                                state_next = S_NBR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // insert: rd_data = entry idx-1 ; delete: rd_data = entry idx+1
            S_SHIFT:
            begin
                wr_en = 1'b1;
                if (act_reg == ACT_INSERT)
                begin
                    if (idx_reg == lo_reg)
                    begin
                        wr_data    = u_reg;
                        count_next = count_reg + 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        wr_data  = rd_u;
                        idx_next = idx_reg - 1'b1;
                        rd_idx   = idx_reg - 2'd2;
                    end
                end
                else
                begin
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        wr_en      = 1'b0;
                        count_next = count_reg - 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        wr_data  = rd_u;
                        idx_next = idx_reg + 1'b1;
                        rd_idx   = idx_reg + 2'd2;
                    end
                end
            end
            // prev always has its neighbor here; next only below the count
            S_NBR:
            begin
                state_next = S_OUT;
                if ((act_reg == ACT_PREV) || (idx_reg < count_reg))
                begin
                    res_next = '{found: 1'b1,
                        neighbor_key: {~rd_u[31], rd_u[30:0]}, status: ST_DONE};
                end
            end
            // hand over to the output register once it is free
            S_OUT:
            begin
                if (!rv_reg || res_ready)
                begin
                    rv_next    = 1'b1;
                    out_next   = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        u_reg    <= u_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        idx_reg  <= idx_next;
        pres_reg <= pres_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("count over capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && act_reg == ACT_DELETE) |-> pres_reg)
        else $error("delete shift without hit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted twice");
endmodule

@@ hw/rtl/ordered_key_set.sv @@
// Ordered key set: signed 32-bit keys kept sorted in one on-chip memory.
// Slave channel s_axis carries a request: action and key. Master channel
// m_axis returns exactly one result per request: found, neighbor key,
// status (0 done, 1 none/absent, 2 full).
// One request is worked at a time. Lookup is a binary search, each probe
// a read issued in S_SRCH and checked in S_CHK through the single read
// port. Insert and delete then shift the tail one entry per cycle.
// Reset clears the key count, the state and the result-valid flag; memory contents need no clearing.
// The result sits in an output register until m_axis_tready is high;
// meanwhile the next request is taken and worked, and it waits for the
// output register to free before its own result is handed over.
module ordered_key_set #(
    parameter int CAPACITY = oks_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // action[2:0], key[34:3], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // found[0], neighbor_key[32:1], status[34:33]
);
    import oks_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data, rd_data;
    oks_result_t   res;

    oks_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_action(s_axis_tdata[2:0]), .in_key(s_axis_tdata[34:3]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    oks_store #(.CAPACITY(CAPACITY)) u_store (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign m_axis_tdata = {5'd0, res.status, res.neighbor_key, res.found};
endmodule

@@ test/oks_checker.sv @@
module oks_checker #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    import oks_pkg::*;

    // shadow set, ascending signed order
    logic signed [31:0] shadow_keys[$];
    oks_result_t        expected_results[$];

    // work out the result of one request and update the shadow set
    function automatic oks_result_t apply_request(logic [2:0] act, logic signed [31:0] k);
        oks_result_t r;
        int pos;
        bit present;
        int n;
        n = shadow_keys.size();
        r = '0;
        r.status = ST_NONE;
        pos = 0;
        while (pos < n && shadow_keys[pos] < k)
            pos++;
        present = (pos < n) && (shadow_keys[pos] == k);
        case (act)
            ACT_INSERT:
            begin
                if (present)
                    r.status = ST_DONE;
                else if (n >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_keys.insert(pos, k);
                    r.status = ST_DONE;
                end
            end
            ACT_DELETE:
            begin
                if (present)
                begin
                    shadow_keys.delete(pos);
                    r.status = ST_DONE;
                end
            end
            ACT_EXISTS:
            begin
                if (present)
                begin
                    r.found  = 1'b1;
                    r.status = ST_DONE;
                end
            end
            ACT_NEXT:
            begin
                if (present)
                    pos++;
                if (pos < n)
                begin
                    r.found        = 1'b1;
                    r.neighbor_key = shadow_keys[pos];
                    r.status       = ST_DONE;
                end
            end
            ACT_PREV:
            begin
                if (pos > 0)
                begin
                    r.found        = 1'b1;
                    r.neighbor_key = shadow_keys[pos-1];
                    r.status       = ST_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        oks_result_t want;
        oks_result_t got;
        if (!rst_n)
        begin
            fail_count   <= 0;
            result_count <= 0;
            shadow_keys.delete();
            expected_results.delete();
        end
        else
        begin
            // result side first: a request accepted this edge cannot be answered yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found        = m_axis_tdata[0];
                got.neighbor_key = m_axis_tdata[32:1];
                got.status       = m_axis_tdata[34:33];
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                        $error("found: expected %0d actual %0d", want.found, got.found);
                    if (got.neighbor_key !== want.neighbor_key)
                        $error("neighbor_key: expected %0d actual %0d",
                               $signed(want.neighbor_key), $signed(got.neighbor_key));
                    if (got.status !== want.status)
                        $error("status: expected %0d actual %0d", want.status, got.status);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(apply_request(s_axis_tdata[2:0],
                                                         s_axis_tdata[34:3]));
        end
    end
endmodule

@@ test/tb_top.sv @@
module tb_top;
    import oks_pkg::*;

    localparam int CAPACITY = 64;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          sent_count;
    bit          calm_mode;
    bit          hold_sink;

    ordered_key_set #(.CAPACITY(CAPACITY)) u_top (.*);

    oks_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("FAIL ordered_key_set");
        $finish;
    end

    // receiver: random stalls, optional long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
                m_axis_tready <= 1'b0;
            else if (calm_mode)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 17);
        end
    end

    // offer one request and wait for acceptance; driven only at falling edges
    task automatic send_request(logic [2:0] act, logic signed [31:0] k);
        if (!calm_mode)
            while ($urandom_range(99) < 17)
                @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, k, act};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        sent_count++;
    endtask

    // key drawn mostly from a narrow pool so hits, neighbors and full-store refusals occur
    function automatic logic signed [31:0] pick_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6)
            return $signed($urandom_range(80)) - 40;
        else if (sel == 6)
            return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                     : 32'sh80000000 + $urandom_range(3);
        else
            return $urandom;
    endfunction

    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [2:0] act;
        int idx;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        calm_mode     = 1'b0;
        hold_sink     = 1'b0;
        sent_count    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-store queries, extremes, duplicates, absent keys, unused codes
        send_request(ACT_NEXT, 32'sd0);
        send_request(ACT_PREV, 32'sd0);
        send_request(ACT_DELETE, 32'sd5);
        send_request(ACT_EXISTS, 32'sd5);
        send_request(ACT_INSERT, 32'sh80000000);
        send_request(ACT_INSERT, 32'sh7fffffff);
        send_request(ACT_INSERT, 32'sd0);
        send_request(ACT_INSERT, 32'sd0);
        send_request(ACT_INSERT, -32'sd1);
        send_request(ACT_EXISTS, 32'sd0);
        send_request(ACT_NEXT, 32'sh7fffffff);
        send_request(ACT_PREV, 32'sh80000000);
        send_request(ACT_NEXT, 32'sh80000000);
        send_request(ACT_PREV, 32'sh7fffffff);
        send_request(ACT_NEXT, -32'sd1);
        send_request(ACT_PREV, 32'sd7);
        send_request(3'd5, 32'sd0);
        send_request(3'd6, -32'sd1);
        send_request(3'd7, 32'sh55555555);
        send_request(ACT_DELETE, 32'sd0);
        send_request(ACT_DELETE, 32'sd0);
        send_request(ACT_EXISTS, 32'sd0);

        // sender pauses until the block has answered everything
        wait_drained();

        // fill the store past capacity, starting while the receiver holds off
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(negedge clk);
                hold_sink = 1'b0;
            end
            for (idx = 0; idx < CAPACITY + 6; idx++)
                send_request(ACT_INSERT, 32'sd1000 + idx * 3);
        join
        send_request(ACT_INSERT, 32'sd1000);
        send_request(ACT_INSERT, 32'sh80000000);
        send_request(ACT_NEXT, 32'sd1001);
        send_request(ACT_PREV, 32'sd1001);

        // random part; a calm stretch in the middle with no idling
        for (idx = 0; idx < 1250; idx++)
        begin
            calm_mode = (idx >= 500 && idx < 650);
            act = $urandom_range(99) < 4 ? 3'($urandom_range(7, 5))
                                         : 3'($urandom_range(4));
            // bias toward deletes in the later part of every 200 requests
            if (act == ACT_INSERT && $urandom_range(99) < 35 && idx % 200 > 120)
                act = ACT_DELETE;
            send_request(act, pick_key());
        end
        calm_mode = 1'b0;

        wait_drained();
        repeat (200) @(negedge clk);
        $display("Ran %0d requests with %0d results: all actions, unused codes,",
                 sent_count, result_count);
        $display("full-store refusals, key extremes and long output stalls.");
        if (fail_count == 0 && pending_count == 0)
            $display("PASS ordered_key_set");
        else
            $display("FAIL ordered_key_set");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/oks_pkg.sv
hw/rtl/oks_store.sv
hw/rtl/oks_ctrl.sv
hw/rtl/ordered_key_set.sv
test/oks_checker.sv
test/tb_top.sv
